/* rtl/hrlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrlp_pkg
// Shared constants, codes and pattern lookups for the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] DIGIT_ZERO = 8'd48;
  localparam logic [7:0] DIGIT_ONE  = 8'd49;

  localparam int unsigned TDATA_W = 16;

  // token numbering, saturating at TOK_MAX
  localparam logic [2:0] TOK_NONE    = 3'd0;
  localparam logic [2:0] TOK_METHOD  = 3'd1;
  localparam logic [2:0] TOK_URL     = 3'd2;
  localparam logic [2:0] TOK_VERSION = 3'd3;
  localparam logic [2:0] TOK_MAX     = 3'd4;

  // character positions of interest
  localparam logic [3:0] METHOD_LEN = 4'd3;
  localparam logic [3:0] PREFIX_LEN = 4'd5;
  localparam logic [3:0] MAJOR_POS  = 4'd5;
  localparam logic [3:0] MINOR_POS  = 4'd7;
  localparam logic [3:0] POS_MAX    = 4'd15;

  // minor digit tracking
  localparam logic [1:0] MINOR_NONE = 2'd0;
  localparam logic [1:0] MINOR_ZERO = 2'd1;
  localparam logic [1:0] MINOR_ONE  = 2'd2;
  localparam logic [1:0] MINOR_BAD  = 2'd3;

  typedef struct packed {
    logic [2:0] token_index;
    logic       inside_token;
    logic [3:0] char_position;
    logic       method_match;
    logic       prefix_match;
    logic       major_digit_ok;
    logic [1:0] minor_digit;
    logic       failed;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '0;

  function automatic logic [7:0] method_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h47; // G
      2'd1:    c = 8'h45; // E
      2'd2:    c = 8'h54; // T
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h48; // H
      3'd1:    c = 8'h54; // T
      3'd2:    c = 8'h54; // T
      3'd3:    c = 8'h50; // P
      3'd4:    c = 8'h2f; // /
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* rtl/http_request_line_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_line_parser
// Byte-stream checker for an HTTP request line with URL extraction.
// ----------------------------------------------------------------------------
// One byte per beat in, one result beat out per input beat. The parse state
// is updated from the incoming byte in a single pass and the result lands in
// one output register, so a beat is taken every cycle while the output side
// keeps up. Runs of spaces split tokens; token one must be GET, token two is
// passed out as URL bytes, token three must start HTTP/1, then any byte, then
// x with x of 0 or 1. The verdict comes with the beat carrying s_tlast, after
// which the parser is clear for a new line.
module http_request_line_parser
  import hrlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] line_byte
  input  logic               s_tlast,   // is_last
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [7:0] url_byte, [8] request_ok,
                                        // [9] three_tokens, [10] method_get,
                                        // [11] version_ok, [12] minor_one
  output logic               m_tuser,   // url_byte_valid
  output logic               m_tlast    // line_done
);

  parse_state_t st;
  parse_state_t st_next;
  parse_state_t upd;
  logic         accept;

  logic [7:0] url_byte_next;
  logic       url_valid_next;
  logic       request_ok_next;
  logic       three_next;
  logic       method_get_next;
  logic       version_ok_next;
  logic       minor_next;
  logic       vpass;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    upd            = st;
    url_byte_next  = 8'h00;
    url_valid_next = 1'b0;
    if (s_tdata == SPACE_BYTE) begin
      if (upd.inside_token) begin
        if (upd.token_index == TOK_METHOD) begin
          if (upd.char_position != METHOD_LEN) upd.method_match = 1'b0;
          if (!upd.method_match) upd.failed = 1'b1;
        end else if (upd.token_index == TOK_VERSION) begin
          if (!(upd.prefix_match && upd.major_digit_ok &&
                (upd.minor_digit == MINOR_ZERO || upd.minor_digit == MINOR_ONE)))
            upd.failed = 1'b1;
        end
        upd.inside_token = 1'b0;
      end
    end else begin
      if (!upd.inside_token) begin
        upd.inside_token  = 1'b1;
        if (upd.token_index != TOK_MAX) upd.token_index = upd.token_index + 3'd1;
        upd.char_position = 4'd0;
        if (upd.token_index == TOK_METHOD) upd.method_match = 1'b1;
        if (upd.token_index == TOK_VERSION) begin
          upd.prefix_match   = 1'b1;
          upd.major_digit_ok = 1'b0;
          upd.minor_digit    = MINOR_NONE;
        end
      end
      if (upd.token_index == TOK_METHOD) begin
        if (upd.char_position < METHOD_LEN &&
            s_tdata != method_char(upd.char_position[1:0]))
          upd.method_match = 1'b0;
      end else if (upd.token_index == TOK_URL) begin
        url_byte_next  = s_tdata;
        url_valid_next = 1'b1;
      end else if (upd.token_index == TOK_VERSION) begin
        if (upd.char_position < PREFIX_LEN) begin
          if (s_tdata != prefix_char(upd.char_position[2:0])) upd.prefix_match = 1'b0;
        end else if (upd.char_position == MAJOR_POS) begin
          upd.major_digit_ok = (s_tdata == DIGIT_ONE);
        end else if (upd.char_position == MINOR_POS) begin
          if (s_tdata == DIGIT_ZERO)     upd.minor_digit = MINOR_ZERO;
          else if (s_tdata == DIGIT_ONE) upd.minor_digit = MINOR_ONE;
          else                           upd.minor_digit = MINOR_BAD;
        end
      end
      if (upd.char_position != POS_MAX) upd.char_position = upd.char_position + 4'd1;
    end

    // end of line: close any open token, then report
    if (s_tlast && upd.inside_token) begin
      if (upd.token_index == TOK_METHOD) begin
        if (upd.char_position != METHOD_LEN) upd.method_match = 1'b0;
        if (!upd.method_match) upd.failed = 1'b1;
      end
    end
    vpass = upd.prefix_match && upd.major_digit_ok &&
            (upd.minor_digit == MINOR_ZERO || upd.minor_digit == MINOR_ONE);
    if (s_tlast && upd.inside_token && upd.token_index == TOK_VERSION && !vpass)
      upd.failed = 1'b1;

    request_ok_next = s_tlast && upd.token_index != TOK_NONE && !upd.failed;
    three_next      = s_tlast && upd.token_index >= TOK_VERSION;
    method_get_next = s_tlast && upd.token_index != TOK_NONE && upd.method_match;
    version_ok_next = s_tlast && upd.token_index >= TOK_VERSION && vpass;
    minor_next      = version_ok_next && upd.minor_digit == MINOR_ONE;

    st_next = s_tlast ? STATE_RESET : upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {3'b000, minor_next, version_ok_next, method_get_next,
                  three_next, request_ok_next, url_byte_next};
      m_tuser <= url_valid_next;
      m_tlast <= s_tlast;
    end
  end

`ifndef SYNTH
  a_clear_after_line: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> st.token_index == TOK_NONE && !st.inside_token && !st.failed)
    else $error("parser state not cleared after end of line");

  a_verdict_only_on_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[12:8] == 5'b00000)
    else $error("verdict bits set on a beat that is not the last");

  a_url_not_space: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[7:0] != SPACE_BYTE)
    else $error("space passed out as a URL byte");

  a_minor_needs_version: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[12] |-> m_tdata[11])
    else $error("minor version reported without a valid version token");

  a_ok_three_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] && m_tdata[9] |-> m_tdata[10] && m_tdata[11])
    else $error("request accepted with a failing method or version");
`endif

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the HTTP request line parser. A short table of
// hand-picked lines comes first, then random request lines (mostly well
// formed, some damaged, some noise). Every accepted byte runs through a
// local model of the parser. Each output beat is checked field by field
// against the oldest queued prediction. The sender idles in bursts and the
// receiver stalls on its own schedule.
// ----------------------------------------------------------------------------
module testbench
  import hrlp_pkg::*;
;

  localparam int IDLE_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 800;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] url_byte;
    logic       url_valid;
    logic       line_done;
    logic       request_ok;
    logic       three_tokens;
    logic       method_get;
    logic       version_ok;
    logic       minor_one;
  } line_result_t;

  typedef struct packed {
    logic [7:0]   b;
    logic         last;
    logic         typed;
    line_result_t res;
  } dir_row_t;

  localparam logic [7:0] GET_TEXT   [0:2] = '{8'h47, 8'h45, 8'h54};
  localparam logic [7:0] PROTO_TEXT [0:4] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2f};

  localparam line_result_t NO_TYPED      = '0;
  localparam line_result_t DONE_REJECT   = '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam line_result_t DONE_GET_ONLY = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
  localparam line_result_t DONE_HTTP11   = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
  localparam line_result_t URL_FF        = '{8'hff, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  // spaces only; lone zero byte; lone 0xff; short method; method alone;
  // then a full request with an 0xff URL
  localparam dir_row_t DIR_ROWS [0:21] = '{
    '{8'h20, 1'b1, 1'b1, DONE_REJECT},
    '{8'h00, 1'b1, 1'b1, DONE_REJECT},
    '{8'hff, 1'b1, 1'b1, DONE_REJECT},
    '{"G",   1'b0, 1'b0, NO_TYPED},
    '{"E",   1'b1, 1'b1, DONE_REJECT},
    '{"G",   1'b0, 1'b0, NO_TYPED},
    '{"E",   1'b0, 1'b0, NO_TYPED},
    '{"T",   1'b1, 1'b1, DONE_GET_ONLY},
    '{"G",   1'b0, 1'b0, NO_TYPED},
    '{"E",   1'b0, 1'b0, NO_TYPED},
    '{"T",   1'b0, 1'b0, NO_TYPED},
    '{8'h20, 1'b0, 1'b0, NO_TYPED},
    '{8'hff, 1'b0, 1'b1, URL_FF},
    '{8'h20, 1'b0, 1'b0, NO_TYPED},
    '{"H",   1'b0, 1'b0, NO_TYPED},
    '{"T",   1'b0, 1'b0, NO_TYPED},
    '{"T",   1'b0, 1'b0, NO_TYPED},
    '{"P",   1'b0, 1'b0, NO_TYPED},
    '{"/",   1'b0, 1'b0, NO_TYPED},
    '{"1",   1'b0, 1'b0, NO_TYPED},
    '{".",   1'b0, 1'b0, NO_TYPED},
    '{"1",   1'b1, 1'b1, DONE_HTTP11}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = 8'h00;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  logic                row_typed = 1'b0;
  line_result_t        row_result = '0;

  parse_state_t        parser_st = STATE_RESET;
  line_result_t        pending_results[$];
  line_result_t        predicted;
  line_result_t        wanted;
  logic [7:0]          line_buf[$];
  int                  mismatches = 0;
  int                  items_sent = 0;
  int                  burst_left = 0;
  int                  idle_cycles = 0;
  int                  ready_left = 0;
  int                  ready_mode = 0;

  http_request_line_parser u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---- line model --------------------------------------------------------

  function automatic logic version_good();
    return parser_st.prefix_match && parser_st.major_digit_ok &&
           (parser_st.minor_digit == MINOR_ZERO || parser_st.minor_digit == MINOR_ONE);
  endfunction

  function automatic void end_token();
    if (!parser_st.inside_token) return;
    if (parser_st.token_index == TOK_METHOD) begin
      if (parser_st.char_position != METHOD_LEN) parser_st.method_match = 1'b0;
      if (!parser_st.method_match) parser_st.failed = 1'b1;
    end else if (parser_st.token_index == TOK_VERSION) begin
      if (!version_good()) parser_st.failed = 1'b1;
    end
    parser_st.inside_token = 1'b0;
  endfunction

  function automatic line_result_t parse_byte(input logic [7:0] b, input logic last);
    line_result_t r;
    logic [3:0]   p;
    logic         vok;
    r = '0;
    if (b == SPACE_BYTE) begin
      end_token();
    end else begin
      if (!parser_st.inside_token) begin
        parser_st.inside_token = 1'b1;
        if (parser_st.token_index < TOK_MAX) parser_st.token_index = parser_st.token_index + 3'd1;
        parser_st.char_position = 4'd0;
        if (parser_st.token_index == TOK_METHOD) parser_st.method_match = 1'b1;
        if (parser_st.token_index == TOK_VERSION) begin
          parser_st.prefix_match   = 1'b1;
          parser_st.major_digit_ok = 1'b0;
          parser_st.minor_digit    = MINOR_NONE;
        end
      end
      p = parser_st.char_position;
      case (parser_st.token_index)
        TOK_METHOD: begin
          if (p < METHOD_LEN && b != GET_TEXT[p[1:0]]) parser_st.method_match = 1'b0;
        end
        TOK_URL: begin
          r.url_byte  = b;
          r.url_valid = 1'b1;
        end
        TOK_VERSION: begin
          if (p < PREFIX_LEN) begin
            if (b != PROTO_TEXT[p[2:0]]) parser_st.prefix_match = 1'b0;
          end else if (p == MAJOR_POS) begin
            parser_st.major_digit_ok = (b == DIGIT_ONE);
          end else if (p == MINOR_POS) begin
            if (b == DIGIT_ZERO)     parser_st.minor_digit = MINOR_ZERO;
            else if (b == DIGIT_ONE) parser_st.minor_digit = MINOR_ONE;
            else                     parser_st.minor_digit = MINOR_BAD;
          end
        end
        default: ;
      endcase
      if (parser_st.char_position < POS_MAX)
        parser_st.char_position = parser_st.char_position + 4'd1;
    end
    if (last) begin
      end_token();
      vok = (parser_st.token_index >= TOK_VERSION) && version_good();
      r.line_done     = 1'b1;
      r.request_ok    = (parser_st.token_index >= TOK_METHOD) && !parser_st.failed;
      r.three_tokens  = (parser_st.token_index >= TOK_VERSION);
      r.method_get    = (parser_st.token_index >= TOK_METHOD) && parser_st.method_match;
      r.version_ok    = vok;
      r.minor_one     = vok && (parser_st.minor_digit == MINOR_ONE);
      parser_st = STATE_RESET;
    end
    return r;
  endfunction

  // ---- scoreboard --------------------------------------------------------

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predicted = parse_byte(s_tdata, s_tlast);
      pending_results.push_back(row_typed ? row_result : predicted);
    end
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("output beat with nothing expected");
        mismatches++;
      end else begin
        wanted = pending_results.pop_front();
        check_field("url_byte",       wanted.url_byte, m_tdata[7:0]);
        check_field("url_byte_valid", {7'd0, wanted.url_valid}, {7'd0, m_tuser});
        check_field("line_done",      {7'd0, wanted.line_done}, {7'd0, m_tlast});
        check_field("request_ok",     {7'd0, wanted.request_ok}, {7'd0, m_tdata[8]});
        check_field("three_tokens",   {7'd0, wanted.three_tokens}, {7'd0, m_tdata[9]});
        check_field("method_get",     {7'd0, wanted.method_get}, {7'd0, m_tdata[10]});
        check_field("version_ok",     {7'd0, wanted.version_ok}, {7'd0, m_tdata[11]});
        check_field("minor_one",      {7'd0, wanted.minor_one}, {7'd0, m_tdata[12]});
      end
    end
  end

  // ---- receiver stalls ---------------------------------------------------

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(8, 64);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // ---- watchdog ----------------------------------------------------------

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---- sender ------------------------------------------------------------

  task automatic put_byte(input logic [7:0] b, input logic last, input logic typed,
                          input line_result_t res);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid   <= 1'b1;
    s_tdata    <= b;
    s_tlast    <= last;
    row_typed  <= typed;
    row_result <= res;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [7:0] token_char();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == SPACE_BYTE) b = ~b;
    return b;
  endfunction

  function automatic void add_spaces(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) line_buf.push_back(SPACE_BYTE);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_junk(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) line_buf.push_back(token_char());
  endfunction

  function automatic void build_request();
    int vs;
    int n;
    if ($urandom_range(0, 5) == 0) add_spaces(1, 2);
    case ($urandom_range(0, 9))
      0:       add_junk(1, 20);
      1:       add_text("GE");
      2: begin add_text("GET"); add_junk(1, 14); end
      3: begin add_text("GET"); line_buf[$urandom_range(0, 2)] = token_char(); end
      default: add_text("GET");
    endcase
    if ($urandom_range(0, 15) == 0) return;
    add_spaces(1, 3);
    n = $urandom_range(1, 20);
    line_buf.push_back("/");
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) line_buf.push_back(token_char());
      else line_buf.push_back(8'($urandom_range(8'h21, 8'h7e)));
    end
    if ($urandom_range(0, 7) == 0) return;
    add_spaces(1, 2);
    vs = line_buf.size();
    add_text("HTTP/");
    if ($urandom_range(0, 7) == 0) line_buf[vs + $urandom_range(0, 4)] = token_char();
    line_buf.push_back(($urandom_range(0, 7) == 0) ? token_char() : DIGIT_ONE);
    line_buf.push_back(($urandom_range(0, 7) == 0) ? token_char() : ".");
    case ($urandom_range(0, 4))
      0:       line_buf.push_back(token_char());
      1, 2:    line_buf.push_back(DIGIT_ZERO);
      default: line_buf.push_back(DIGIT_ONE);
    endcase
    case ($urandom_range(0, 5))
      0:       add_text("\r\n");
      1:       add_junk(1, 12);
      2: begin
        n = $urandom_range(1, 7);
        while (line_buf.size() > vs + n) void'(line_buf.pop_back());
      end
      default: ;
    endcase
    if ($urandom_range(0, 5) == 0) begin add_spaces(1, 2); add_junk(1, 6); end
    if ($urandom_range(0, 5) == 0) add_spaces(1, 3);
  endfunction

  task automatic send_random_line();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      build_request();
    end else if (kind < 9) begin
      repeat ($urandom_range(1, 12))
        line_buf.push_back(($urandom_range(0, 3) == 0) ? SPACE_BYTE : 8'($urandom));
    end else begin
      add_spaces(1, 3);
    end
    foreach (line_buf[i])
      put_byte(line_buf[i], i == line_buf.size() - 1, 1'b0, NO_TYPED);
    items_sent += line_buf.size();
    line_buf.delete();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (DIR_ROWS[i])
      put_byte(DIR_ROWS[i].b, DIR_ROWS[i].last, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    while (items_sent < RANDOM_BYTES) send_random_line();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected beats never arrived", pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

/* http_request_line_parser.f */
rtl/hrlp_pkg.sv
rtl/http_request_line_parser.sv
test/testbench.sv
